/* rtl/gravity_tare_rotation_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gravity tare rotation block
// Shared helpers for the concurrent checks at the end of each design module.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_TARE_ROTATION_TOP_MACROS_SVH
`define GRAVITY_TARE_ROTATION_TOP_MACROS_SVH

// property that holds outside reset
`define GTR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication, consequent checked in the next cycle
`define GTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gtr_pkg.sv */
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared widths, constants and helpers for the gravity tare rotation block.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int DataW   = 16;
  localparam int ThrW    = 15;
  localparam int OneQ14  = 16384;
  localparam logic signed [ThrW-1:0] ThrReset = -15'sd16368;

  // serial multiplier / divider operation codes
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

/* rtl/gtr_serial_unit.sv */
// ----------------------------------------------------------------------------
// gtr_serial_unit
// Bit-serial multiply (shift-add) and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module gtr_serial_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  logic signed [31:0] a,      // mul: multiplicand, div: dividend
  input  logic signed [17:0] b,      // mul: multiplier,   div: divisor (>0)
  output logic               done,
  output logic signed [47:0] res
);
  import gtr_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [1:0]  cur_op;
  logic        neg;
  logic [31:0] mag_a;
  logic [17:0] mag_b;
  logic [47:0] acc;
  logic [31:0] quo;
  logic [18:0] rem;
  logic [18:0] rem_sh;
  logic [32:0] num_rnd;

  assign rem_sh = {rem[17:0], quo[31]};

  always_comb begin
    num_rnd = {1'b0, mag_a} + {16'd0, mag_b[17:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy   <= 1'b1;
        done   <= 1'b0;
        cur_op <= op;
        neg    <= a[31] ^ ((op == OP_MUL) && b[17]);
        mag_a  <= a[31] ? 32'(-a) : 32'(a);
        mag_b  <= (op == OP_MUL && b[17]) ? 18'(-b) : 18'(b);
        acc    <= '0;
        rem    <= '0;
        cnt    <= 6'd0;
      end else if (busy) begin
        case (cur_op)
          OP_MUL: begin
            if (mag_b[cnt[4:0]]) begin
              acc <= acc + ({16'd0, mag_a} << cnt[4:0]);
            end
            if (cnt == 6'd17) begin
              busy <= 1'b0;
            end
            done <= (cnt == 6'd17);
            cnt <= cnt + 6'd1;
          end
          OP_DIV: begin
            if (cnt == 6'd0) begin
              quo <= num_rnd[31:0];
              rem <= '0;
            end else begin
              if (rem_sh >= {1'b0, mag_b}) begin
                rem <= rem_sh - {1'b0, mag_b};
                quo <= {quo[30:0], 1'b1};
              end else begin
                rem <= rem_sh;
                quo <= {quo[30:0], 1'b0};
              end
              if (cnt == 6'd32) begin
                busy <= 1'b0;
              end
            end
            done <= (cnt == 6'd32);
            cnt <= cnt + 6'd1;
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b0;
          end
        endcase
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_comb begin
    if (cur_op == OP_MUL) begin
      res = neg ? -$signed(acc) : $signed(acc);
    end else begin
      res = neg ? -$signed({16'd0, quo}) : $signed({16'd0, quo});
    end
  end

  `include "gravity_tare_rotation_top_macros.svh"
  `GTR_ASSERT_NEXT(a_no_restart, clk, rst, busy, !start, "start while busy")
  `GTR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held")
  `GTR_ASSERT(a_div_pos, clk, rst, !(start && op == OP_DIV) || b > 0, "div by <= 0")

endmodule

/* rtl/gravity_tare_rotation_top.sv */
// ----------------------------------------------------------------------------
// gravity_tare_rotation_top
// Tare rotation: aligns the tare gravity vector with -z and rotates samples.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | grav_x/y/z, tare/untare_request
// out     | output    | out_valid / out_stall| out_x/y/z, is_tared
// cfg     | input     | cfg_we               | cfg_wdata (singular_threshold)
//
// One sample at a time. All multiplies and divides run on one shared
// bit-serial unit. Plain sample: no unit work. Tared sample: 9 multiplies.
// A tare above the singular threshold adds 3 squares/products and 3 divides.
// rst is synchronous; it restores identity matrix, tared clear, threshold.
// A stalled result holds in the output register; a new sample may still be
// accepted, and its result waits in S_OUT until the output register is free.
// ----------------------------------------------------------------------------
module gravity_tare_rotation_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic signed [gtr_pkg::ThrW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          grav_x,
  input  logic signed [15:0]          grav_y,
  input  logic signed [15:0]          grav_z,
  input  logic                        tare_request,
  input  logic                        untare_request,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_x,
  output logic signed [15:0]          out_y,
  output logic signed [15:0]          out_z,
  output logic                        is_tared
);
  import gtr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BLD  = 3'd1;  // build matrix products/divides
  localparam logic [2:0] S_MAC  = 3'd2;  // row dot products
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]  state;
  logic signed [ThrW-1:0] thr;
  logic signed [15:0] mat [9];
  logic        tared;
  logic signed [15:0] gx, gy, gz;
  logic [3:0]  step;
  logic        issued;
  logic signed [47:0] sum;
  logic signed [47:0] tmp;
  logic signed [15:0] rx, ry, rz;

  logic               su_start;
  logic [1:0]         su_op;
  logic signed [31:0] su_a;
  logic signed [17:0] su_b;
  logic               su_done;
  logic signed [47:0] su_res;

  gtr_serial_unit u_su (
    .clk(clk), .rst(rst), .start(su_start), .op(su_op), .a(su_a), .b(su_b),
    .done(su_done), .res(su_res)
  );

  // build values
  logic signed [16:0] c_v, vx_v, vy_v;
  logic signed [17:0] d_v;
  assign c_v  = -17'(gz);
  assign vx_v = -17'(gy);
  assign vy_v = 17'(gx);
  assign d_v  = 18'(OneQ14) + 18'(c_v);

  // build schedule: 0 vx*vx, 1 /d, 2 vy*vy, 3 /d, 4 vx*vy, 5 /d
  always_comb begin
    su_op = OP_MUL;
    su_a  = '0;
    su_b  = '0;
    if (state == S_BLD) begin
      case (step)
        4'd0: begin su_a = 32'(vx_v); su_b = 18'(vx_v); end
        4'd2: begin su_a = 32'(vy_v); su_b = 18'(vy_v); end
        4'd4: begin su_a = 32'(vx_v); su_b = 18'(vy_v); end
        default: begin su_op = OP_DIV; su_a = tmp[31:0]; su_b = d_v; end
      endcase
    end else if (state == S_MAC) begin
      su_a = 32'(mat[step]);
      case (step)
        4'd0, 4'd3, 4'd6: su_b = 18'(gx);
        4'd1, 4'd4, 4'd7: su_b = 18'(gy);
        default: su_b = 18'(gz);
      endcase
    end
  end

  assign su_start = (state == S_BLD || state == S_MAC) && !issued;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      thr   <= ThrReset;
      tared <= 1'b0;
      issued <= 1'b0;
      step  <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        mat[k] <= (k % 4 == 0) ? 16'sd16384 : 16'sd0;
      end
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      // S_OUT either holds or reloads the register, so it never clears here
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            gx <= grav_x; gy <= grav_y; gz <= grav_z;
            step <= '0; issued <= 1'b0; sum <= '0;
            if (tare_request) begin
              tared <= 1'b1;
              if (-17'(grav_z) > 17'(thr)) begin
                state <= S_BLD;
              end else begin
                for (int k = 0; k < 9; k++) begin
                  mat[k] <= (k == 0) ? 16'sd16384 : (k % 4 == 0) ? -16'sd16384 : 16'sd0;
                end
                state <= S_MAC;
              end
            end else begin
              if (untare_request) begin
                tared <= 1'b0;
              end
              state <= tared && !untare_request ? S_MAC : S_OUT;
            end
          end
        end
        S_BLD: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (su_done) begin
            issued <= 1'b0;
            tmp <= su_res;
            case (step)
              4'd1: mat[0] <= sat16(48'(c_v) + su_res);
              4'd3: mat[4] <= sat16(48'(c_v) + su_res);
              4'd5: begin
                mat[1] <= sat16(su_res);
                mat[3] <= sat16(su_res);
                mat[2] <= sat16(48'(vy_v));
                mat[5] <= sat16(-48'(vx_v));
                mat[6] <= sat16(-48'(vy_v));
                mat[7] <= sat16(48'(vx_v));
                mat[8] <= sat16(48'(c_v));
              end
              default: ;
            endcase
            if (step == 4'd5) begin
              step  <= '0;
              state <= S_MAC;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        S_MAC: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (su_done) begin
            issued <= 1'b0;
            if (step == 4'd2 || step == 4'd5 || step == 4'd8) begin
              case (step)
                4'd2: rx <= sat16((sum + su_res + 48'sd8192) >>> 14);
                4'd5: ry <= sat16((sum + su_res + 48'sd8192) >>> 14);
                default: rz <= sat16((sum + su_res + 48'sd8192) >>> 14);
              endcase
              sum <= '0;
            end else begin
              sum <= sum + su_res;
            end
            if (step == 4'd8) begin
              state <= S_OUT;
            end
            step <= step + 4'd1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            is_tared  <= tared;
            out_x <= tared ? rx : gx;
            out_y <= tared ? ry : gy;
            out_z <= tared ? rz : gz;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  `include "gravity_tare_rotation_top_macros.svh"
  `GTR_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state != S_IDLE, "accept stayed idle")
  `GTR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_x), "out changed")
  `GTR_ASSERT(a_step_range, clk, rst, step <= 4'd9, "step overrun")

endmodule

/* tb/gtr_checker.sv */
// ----------------------------------------------------------------------------
// gtr_checker
// Watches the sample, result and threshold ports of the tare rotation block,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic signed [gtr_pkg::ThrW-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [15:0]              grav_x,
  input  logic signed [15:0]              grav_y,
  input  logic signed [15:0]              grav_z,
  input  logic                            tare_request,
  input  logic                            untare_request,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [15:0]              out_x,
  input  logic signed [15:0]              out_y,
  input  logic signed [15:0]              out_z,
  input  logic                            is_tared,
  output int                              fail_count,
  output int                              pending
);

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               tared;
  } grav_result_t;

  grav_result_t       expected_q[$];
  logic signed [15:0] rot[9];
  logic               tared;
  longint             thr;

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // nearest, ties away from zero
  function automatic longint div_round(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Q28 sum to Q14, round half up
  function automatic longint q28_round(longint s);
    longint t;
    t = s + 8192;
    if (t >= 0) return t / 16384;
    return -((-t + 16383) / 16384);
  endfunction

  task automatic reset_model();
    foreach (rot[k]) rot[k] = '0;
    rot[0] = 16384;
    rot[4] = 16384;
    rot[8] = 16384;
    tared = 1'b0;
    thr = -16368;
    expected_q.delete();
  endtask

  task automatic build_rotation(longint x, longint y, longint z);
    longint c, vx, vy, d, qxy;
    c = -z;
    vx = -y;
    vy = x;
    foreach (rot[k]) rot[k] = '0;
    if (c > thr) begin
      d = 16384 + c;
      qxy = div_round(vx * vy, d);
      rot[0] = clip16(c + div_round(vx * vx, d));
      rot[1] = clip16(qxy);
      rot[2] = clip16(vy);
      rot[3] = clip16(qxy);
      rot[4] = clip16(c + div_round(vy * vy, d));
      rot[5] = clip16(-vx);
      rot[6] = clip16(-vy);
      rot[7] = clip16(vx);
      rot[8] = clip16(c);
    end else begin
      // near-singular: fixed half turn about x
      rot[0] = 16384;
      rot[4] = -16384;
      rot[8] = -16384;
    end
  endtask

  task automatic predict_sample();
    grav_result_t r;
    longint g[3];
    longint rowsum[3];
    g[0] = grav_x;
    g[1] = grav_y;
    g[2] = grav_z;
    if (tare_request) begin
      build_rotation(g[0], g[1], g[2]);
      tared = 1'b1;
    end else if (untare_request) begin
      tared = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      rowsum[i] = longint'(rot[i*3]) * g[0] + longint'(rot[i*3+1]) * g[1]
                + longint'(rot[i*3+2]) * g[2];
    end
    r.x = tared ? clip16(q28_round(rowsum[0])) : grav_x;
    r.y = tared ? clip16(q28_round(rowsum[1])) : grav_y;
    r.z = tared ? clip16(q28_round(rowsum[2])) : grav_z;
    r.tared = tared;
    expected_q.push_back(r);
  endtask

  task automatic check_result();
    grav_result_t e;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result %0d %0d %0d tared=%0b",
                 $realtime, out_x, out_y, out_z, is_tared);
      return;
    end
    e = expected_q.pop_front();
    if (out_x !== e.x || out_y !== e.y || out_z !== e.z || is_tared !== e.tared) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch exp %0d %0d %0d tared=%0b got %0d %0d %0d tared=%0b",
                 $realtime, e.x, e.y, e.z, e.tared, out_x, out_y, out_z, is_tared);
    end
  endtask

  initial begin
    fail_count = 0;
    reset_model();
  end

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_we) thr = cfg_wdata;
      if (in_valid && !in_stall) predict_sample();
      if (out_valid && !out_stall) check_result();
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives gravity samples, tare and untare requests through the tare rotation
// block under several singular thresholds, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int QuietLimit = 20000; // cycles with no transfer before giving up
  localparam int PhaseItems = 480;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic signed [gtr_pkg::ThrW-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic signed [15:0]              grav_x = '0;
  logic signed [15:0]              grav_y = '0;
  logic signed [15:0]              grav_z = '0;
  logic                            tare_request = 1'b0;
  logic                            untare_request = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [15:0]              out_x;
  logic signed [15:0]              out_y;
  logic signed [15:0]              out_z;
  logic                            is_tared;

  int     fail_count;
  int     pending;
  int     samples_sent = 0;
  int     tares_sent = 0;
  int     idle_cycles = 0;
  logic   gaps_on = 1'b1;   // cleared for a stretch with no idling at all
  longint cur_thr = -16368;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gravity_tare_rotation_top DUT (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .grav_x, .grav_y, .grav_z, .tare_request, .untare_request,
    .out_valid, .out_stall, .out_x, .out_y, .out_z, .is_tared
  );

  gtr_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .grav_x, .grav_y, .grav_z, .tare_request, .untare_request,
    .out_valid, .out_stall, .out_x, .out_y, .out_z, .is_tared,
    .fail_count, .pending
  );

  // Result side: stall about 12% of cycles, except in the quiet stretch.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 12);
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= QuietLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // One sample transfer. valid stays high into the next item when no gap is
  // taken, so it is never dropped and raised in the same step.
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic tare, logic untare);
    while (gaps_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    grav_x <= x;
    grav_y <= y;
    grav_z <= z;
    tare_request <= tare;
    untare_request <= untare;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (tare) tares_sent++;
  endtask

  // Threshold writes only happen once every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_threshold(longint v);
    cfg_we <= 1'b1;
    cfg_wdata <= v[gtr_pkg::ThrW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_thr = v;
  endtask

  task automatic random_sample();
    logic signed [15:0] x, y, z;
    int kind, op;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // roughly unit gravity with some tilt
      x = $signed(16'($urandom_range(16000))) - 16'sd8000;
      y = $signed(16'($urandom_range(16000))) - 16'sd8000;
      z = $signed(16'($urandom_range(32768))) - 16'sd16384;
    end else if (kind < 60) begin
      // hug the singular threshold: c = -z near cur_thr
      x = $signed(16'($urandom_range(400))) - 16'sd200;
      y = $signed(16'($urandom_range(400))) - 16'sd200;
      z = 16'(-cur_thr + longint'($urandom_range(6)) - 3);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end
    op = $urandom_range(99);
    send_sample(x, y, z, op < 10 || op >= 97, (op >= 10 && op < 16) || op >= 97);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pass-through extremes, tare cases, untare, both requests.
    send_sample(16'sh7fff, 16'sh8000, 16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 16'shffff, 1'b0, 1'b1);
    send_sample(16'sd0, 16'sd0, -16'sd16384, 1'b1, 1'b0);     // already down
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b0);  // rotate extremes
    send_sample(16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b0);      // upside down, flip
    send_sample(16'sd1000, -16'sd2000, 16'sd3000, 1'b0, 1'b0);
    send_sample(16'sd0, 16'sd0, 16'sd16368, 1'b1, 1'b0);      // exactly at threshold
    send_sample(16'sd5, 16'sd7, 16'sd16367, 1'b1, 1'b0);      // just past it
    send_sample(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1, 1'b0); // c = 32768, saturation
    send_sample(16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 1'b1); // both: tare wins
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0);
    send_sample(16'sd11585, 16'sd0, -16'sd11585, 1'b1, 1'b0); // 45 degree tilt
    send_sample(16'sd0, 16'sd0, -16'sd16384, 1'b0, 1'b0);
    send_sample(16'sd100, 16'sd200, 16'sd300, 1'b0, 1'b1);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    drain();

    // Threshold extremes: at -16384 the divisor can drop to one.
    write_threshold(-16384);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b0);
    send_sample(16'sd3, -16'sd2, 16'sd16383, 1'b1, 1'b0);     // d = 1
    send_sample(16'sh7fff, 16'sh8000, 16'sd16383, 1'b1, 1'b0);
    send_sample(16'sd200, 16'sd300, -16'sd16000, 1'b0, 1'b0);
    drain();
    write_threshold(0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);          // c = 0, flip
    send_sample(16'sd0, 16'sd0, -16'sd1, 1'b1, 1'b0);         // c = 1, Rodrigues
    send_sample(16'sd9000, -16'sd4000, 16'sd2000, 1'b0, 1'b0);
    drain();

    // Random phases under different thresholds; the sender waits for every
    // result between phases, and the third phase runs with no gaps at all.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_threshold(-16368);
        1: write_threshold(-16384);
        2: write_threshold(0);
        default: write_threshold(-longint'($urandom_range(16384)));
      endcase
      gaps_on = (phase != 2);
      for (int n = 0; n < PhaseItems; n++) random_sample();
      drain();
    end
    gaps_on = 1'b1;

    repeat (600) @(posedge clk);
    $display("Covered %0d samples, %0d tare builds, four threshold phases plus extremes.",
             samples_sent, tares_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
